/* rtl/bfb_pkg.sv */
package bfb_pkg;

    localparam int GRID_PIXELS = 64;
    localparam int PIX_W       = 6;
    localparam int STORE_DEPTH = 2 ** PIX_W;
    localparam int CH_W        = 8;
    localparam int TIME_W      = 32;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUBLISH_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_BITS      = 2'd2;

    localparam logic CMD_PUSH_BIT = 1'b0;
    localparam logic CMD_CLEAR    = 1'b1;

    typedef enum logic [1:0]
    {
        PHASE_RED   = 2'd0,
        PHASE_GREEN = 2'd1,
        PHASE_BLUE  = 2'd2
    } bfb_phase_t;

    typedef struct packed
    {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } bfb_rgb_t;

    typedef struct packed
    {
        logic             wr;
        logic [PIX_W-1:0] addr;
        bfb_rgb_t         rgb;
        logic             clr;
        logic             pub;
        logic [CH_W-1:0]  fade;
    } bfb_op_t;

    function automatic logic [CH_W-1:0] fade_one(input logic [CH_W-1:0] v,
                                                 input logic [CH_W-1:0] f);
        return (v > f) ? CH_W'(v - f) : '0;
    endfunction

endpackage

/* rtl/bfb_front.sv */
module bfb_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic                          raw_bit,
    input  logic [bfb_pkg::TIME_W-1:0]    now_time,
    input  logic [bfb_pkg::CH_W-1:0]      fade_step,
    input  logic [bfb_pkg::TIME_W-1:0]    publish_interval,
    input  logic                          invert_bits,
    input  logic                          q_full,
    output logic                          q_push,
    output bfb_pkg::bfb_op_t              q_op
);

    logic [7:0]                       shift_byte_reg, shift_byte_next;
    logic [2:0]                       bits_held_reg, bits_held_next;
    bfb_pkg::bfb_phase_t              phase_reg, phase_next;
    logic [bfb_pkg::CH_W-1:0]         held_red_reg, held_red_next;
    logic [bfb_pkg::CH_W-1:0]         held_green_reg, held_green_next;
    logic [bfb_pkg::PIX_W-1:0]        cursor_reg, cursor_next;
    logic [bfb_pkg::TIME_W-1:0]       last_pub_reg, last_pub_next;
    logic                             dirty_reg, dirty_next;

    logic                             accept;
    logic                             bit_in;
    logic [7:0]                       byte_in;
    logic                             need;
    logic                             elapsed;
    logic [bfb_pkg::TIME_W-1:0]       since;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign bit_in   = raw_bit ^ invert_bits;
    assign byte_in  = {shift_byte_reg[6:0], bit_in};
    assign since    = now_time - last_pub_reg;
    assign elapsed  = (last_pub_reg == '0) || (since >= publish_interval);

    always_comb
    begin
        shift_byte_next = shift_byte_reg;
        bits_held_next  = bits_held_reg;
        phase_next      = phase_reg;
        held_red_next   = held_red_reg;
        held_green_next = held_green_reg;
        cursor_next     = cursor_reg;
        last_pub_next   = last_pub_reg;
        dirty_next      = dirty_reg;
        need            = 1'b0;
        q_op            = '0;
        if (accept)
        begin
            if (cmd == bfb_pkg::CMD_CLEAR)
            begin
                q_op.clr      = 1'b1;
                q_op.pub      = 1'b1;
                last_pub_next = now_time;
                dirty_next    = 1'b0;
            end
            else
            begin
                if (bits_held_reg == 3'd7)
                begin
                    shift_byte_next = '0;
                    bits_held_next  = '0;
                    case (phase_reg)
                        bfb_pkg::PHASE_RED:
                        begin
                            held_red_next = byte_in;
                            phase_next    = bfb_pkg::PHASE_GREEN;
                        end
                        bfb_pkg::PHASE_GREEN:
                        begin
                            held_green_next = byte_in;
                            phase_next      = bfb_pkg::PHASE_BLUE;
                        end
                        default:
                        begin
                            q_op.wr        = 1'b1;
                            q_op.addr      = cursor_reg;
                            q_op.rgb.red   = held_red_reg;
                            q_op.rgb.green = held_green_reg;
                            q_op.rgb.blue  = byte_in;
                            dirty_next     = 1'b1;
                            phase_next     = bfb_pkg::PHASE_RED;
                            cursor_next    = (cursor_reg == bfb_pkg::PIX_W'(bfb_pkg::GRID_PIXELS - 1))
                                             ? '0 : cursor_reg + 1'b1;
                        end
                    endcase
                end
                else
                begin
                    shift_byte_next = byte_in;
                    bits_held_next  = bits_held_reg + 1'b1;
                end
                need = (fade_step == '0) ? dirty_next : (dirty_next || (last_pub_reg != '0));
                if (need && elapsed)
                begin
                    q_op.pub      = 1'b1;
                    q_op.fade     = fade_step;
                    last_pub_next = now_time;
                    dirty_next    = 1'b0;
                end
            end
        end
    end

    assign q_push = accept && (q_op.wr || q_op.pub);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_byte_reg <= '0;
            bits_held_reg  <= '0;
            phase_reg      <= bfb_pkg::PHASE_RED;
            held_red_reg   <= '0;
            held_green_reg <= '0;
            cursor_reg     <= '0;
            last_pub_reg   <= '0;
            dirty_reg      <= 1'b0;
        end
        else
        begin
            shift_byte_reg <= shift_byte_next;
            bits_held_reg  <= bits_held_next;
            phase_reg      <= phase_next;
            held_red_reg   <= held_red_next;
            held_green_reg <= held_green_next;
            cursor_reg     <= cursor_next;
            last_pub_reg   <= last_pub_next;
            dirty_reg      <= dirty_next;
        end
    end

endmodule

/* rtl/bfb_fifo.sv */
module bfb_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bfb_pkg::bfb_op_t  push_op,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output bfb_pkg::bfb_op_t  head_op
);

    bfb_pkg::bfb_op_t                 entry_reg [bfb_pkg::FIFO_DEPTH];
    logic [bfb_pkg::FIFO_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [bfb_pkg::FIFO_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [bfb_pkg::FIFO_AW:0]        count_reg, count_next;

    assign full      = (count_reg == (bfb_pkg::FIFO_AW+1)'(bfb_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_op   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (bfb_pkg::FIFO_AW+1)'(push) - (bfb_pkg::FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (bfb_pkg::FIFO_AW+1)'(bfb_pkg::FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

/* rtl/bfb_back.sv */
module bfb_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_valid,
    input  bfb_pkg::bfb_op_t              op,
    output logic                          op_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bfb_pkg::PIX_W-1:0]     out_index,
    output bfb_pkg::bfb_rgb_t             out_rgb,
    output logic                          out_last
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } state_t;

    state_t                               state_reg, state_next;
    logic [bfb_pkg::PIX_W-1:0]            idx_reg, idx_next;
    logic [bfb_pkg::CH_W-1:0]             fade_reg, fade_next;
    logic [bfb_pkg::STORE_DEPTH-1:0]      valid_reg, valid_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [bfb_pkg::PIX_W-1:0]            out_index_reg, out_index_next;
    bfb_pkg::bfb_rgb_t                    out_rgb_reg, out_rgb_next;
    logic                                 out_last_reg, out_last_next;

    bfb_pkg::bfb_rgb_t                    store [bfb_pkg::STORE_DEPTH];
    bfb_pkg::bfb_rgb_t                    rd_data_reg;
    logic                                 rd_ok_reg;
    bfb_pkg::bfb_rgb_t                    cur_pix;
    bfb_pkg::bfb_rgb_t                    faded;
    logic                                 mem_we;
    logic [bfb_pkg::PIX_W-1:0]            mem_addr;
    bfb_pkg::bfb_rgb_t                    mem_wdata;
    logic                                 is_last;

    assign cur_pix     = rd_ok_reg ? rd_data_reg : '0;
    assign faded.red   = bfb_pkg::fade_one(cur_pix.red, fade_reg);
    assign faded.green = bfb_pkg::fade_one(cur_pix.green, fade_reg);
    assign faded.blue  = bfb_pkg::fade_one(cur_pix.blue, fade_reg);
    assign is_last     = (idx_reg == bfb_pkg::PIX_W'(bfb_pkg::GRID_PIXELS - 1));

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        fade_next      = fade_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_index_next = out_index_reg;
        out_rgb_next   = out_rgb_reg;
        out_last_next  = out_last_reg;
        op_pop         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = op.addr;
        mem_wdata      = op.rgb;
        case (state_reg)
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    op_pop = 1'b1;
                    if (op.clr)
                    begin
                        valid_next = '0;
                    end
                    if (op.wr)
                    begin
                        mem_we               = 1'b1;
                        valid_next[op.addr]  = 1'b1;
                    end
                    if (op.pub)
                    begin
                        state_next = ST_READ;
                        idx_next   = '0;
                        fade_next  = op.fade;
                    end
                end
            end
            ST_READ:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                mem_we               = 1'b1;
                mem_addr             = idx_reg;
                mem_wdata            = faded;
                valid_next[idx_reg]  = 1'b1;
                out_valid_next       = 1'b1;
                out_index_next       = idx_reg;
                out_rgb_next         = faded;
                out_last_next        = is_last;
                if (is_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= store[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            fade_reg      <= '0;
            valid_reg     <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_rgb_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            fade_reg      <= fade_next;
            valid_reg     <= valid_next;
            rd_ok_reg     <= valid_reg[idx_reg];
            out_valid_reg <= out_valid_next;
            out_index_reg <= out_index_next;
            out_rgb_reg   <= out_rgb_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_rgb   = out_rgb_reg;
    assign out_last  = out_last_reg;

    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> !out_valid_reg)
        else $error("pixel loaded over an untaken result");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |->
            (out_index_reg == bfb_pkg::PIX_W'(bfb_pkg::GRID_PIXELS - 1)))
        else $error("frame end on wrong pixel");

    a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !op_pop)
        else $error("command taken during frame sweep");

endmodule

/* rtl/bitstream_rgb_frame_buffer_core.sv */
// Path: a publishing item enters the queue at its transfer edge; when the sweep unit is idle it
// pops the item, then reads each pixel and registers its faded value onto m_tvalid and m_tdata.
// Throughput: one input item per cycle while the four-entry command queue has room;
// the sweep unit handles a published frame one pixel at a time, each in a read state and then
// a fade-and-write-back state on a pixel store with one write and one read port, waiting on m_tready.
// Async reset (rst_n) clears all control state; the store reads black through per-pixel valid bits.
module bitstream_rgb_frame_buffer_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bfb_pkg::S_TDATA_W-1:0]     s_tdata,   // raw_bit, now_time, zero pad
    input  logic                              s_tuser,   // cmd
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bfb_pkg::M_TDATA_W-1:0]     m_tdata,   // pixel_index, red, green, blue, zero pad
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [bfb_pkg::CH_W-1:0]         fade_step_reg;
    logic [bfb_pkg::TIME_W-1:0]       publish_interval_reg;
    logic                             invert_bits_reg;

    logic                             q_full;
    logic                             q_push;
    bfb_pkg::bfb_op_t                 q_in_op;
    logic                             q_pop;
    logic                             q_not_empty;
    bfb_pkg::bfb_op_t                 q_head_op;
    logic [bfb_pkg::PIX_W-1:0]        pixel_index;
    bfb_pkg::bfb_rgb_t                pixel_rgb;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_step_reg        <= '0;
            publish_interval_reg <= '0;
            invert_bits_reg      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bfb_pkg::REG_FADE_STEP:        fade_step_reg        <= cfg_data[bfb_pkg::CH_W-1:0];
                bfb_pkg::REG_PUBLISH_INTERVAL: publish_interval_reg <= cfg_data[bfb_pkg::TIME_W-1:0];
                bfb_pkg::REG_INVERT_BITS:      invert_bits_reg      <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    bfb_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .cmd              (s_tuser),
        .raw_bit          (s_tdata[0]),
        .now_time         (s_tdata[bfb_pkg::TIME_W:1]),
        .fade_step        (fade_step_reg),
        .publish_interval (publish_interval_reg),
        .invert_bits      (invert_bits_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_op             (q_in_op)
    );

    bfb_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_op   (q_in_op),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_op   (q_head_op)
    );

    bfb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (q_not_empty),
        .op        (q_head_op),
        .op_pop    (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (pixel_index),
        .out_rgb   (pixel_rgb),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, pixel_rgb.blue, pixel_rgb.green, pixel_rgb.red, pixel_index};

endmodule
